/* rtl/min_jerk_trajectory_generator_macros.svh */
// assertion macros for the minimum-jerk trajectory generator
// no dependencies; SYNTH selects empty bodies
`ifndef MIN_JERK_TRAJECTORY_GENERATOR_MACROS_SVH
`define MIN_JERK_TRAJECTORY_GENERATOR_MACROS_SVH
`ifndef SYNTH
`define MJ_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
`define MJ_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MJ_ASSERT(label, clk, rst_n, prop)
`define MJ_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/mjtg_pkg.sv */
// types and constants for the minimum-jerk trajectory generator
// no dependencies
package mjtg_pkg;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_ABORT = 2'd1,
    CMD_TICK  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_REJ   = 2'd1,
    ST_SHORT = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]         command;
    logic               joint;
    logic signed [31:0] current_position;
    logic signed [31:0] target_position;
    logic signed [15:0] speed;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] position;
    logic [1:0]         status;
    logic               moving;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_MUL, S_POLY, S_TRAV, S_OUT
  } state_e;

endpackage

/* rtl/mjtg_divider.sv */
// restoring divider, one quotient bit per cycle
// depends on nothing
module mjtg_divider #(
  parameter int unsigned NW = 64,
  parameter int unsigned DW = 33
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [NW-1:0] num_i,
  input  logic [DW-1:0] den_i,
  output logic          done_o,
  output logic [NW-1:0] quot_o
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] quot_q, quot_d;
  logic [DW:0]   rem_q, rem_d;
  logic [DW-1:0] den_q, den_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          busy_q, busy_d;
  logic [DW:0]   trial;

  always_comb begin
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    trial  = {rem_q[DW-1:0], quot_q[NW-1]};
    if (start_i) begin
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
      cnt_d  = CW'(NW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d  = trial - {1'b0, den_q};
        quot_d = {quot_q[NW-2:0], 1'b1};
      end else begin
        rem_d  = trial;
        quot_d = {quot_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CW'(1));
  assign quot_o = quot_d;
endmodule

/* rtl/min_jerk_trajectory_generator.sv */
// minimum-jerk setpoint generator: sequencer, joint state, shared multiplier
// depends on mjtg_pkg, mjtg_divider and the macros header
//
// channel | direction | handshake            | payload
// in      | input     | in_valid_i/in_stall_o  | mjtg_pkg::in_item_t
// out     | output    | out_valid_o/out_stall_i| mjtg_pkg::out_item_t
// cfg     | input     | cfg_we_i               | period_ms (8 bit)
//
// abort, idle, first or last tick, ignored command, rejected or too short start: result set in decode
// accepted start: result waits for the bit-serial divider
// moving tick: four multiplier passes for the powers, clamp, scale by travel
// one item at a time; in_stall_o is high until the result is taken
// reset idles all joints and sets period_ms to 1
`include "min_jerk_trajectory_generator_macros.svh"
module min_jerk_trajectory_generator #(
  parameter int unsigned JOINTS          = 2,
  parameter int unsigned PHASE_FRAC_BITS = 24
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mjtg_pkg::in_item_t   in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mjtg_pkg::out_item_t  out_item_o,
  input  logic                 cfg_we_i,
  input  logic [7:0]           cfg_wdata_i
);
  localparam int unsigned F  = PHASE_FRAC_BITS;
  localparam int unsigned PW = F + 1;
  localparam int unsigned NW = 24 + F;
  localparam int unsigned JW = (JOINTS > 1) ? $clog2(JOINTS) : 1;
  localparam logic [PW-1:0] ONE = PW'(1) << F;

  logic signed [31:0] start_q [JOINTS];
  logic signed [31:0] final_q [JOINTS];
  logic signed [32:0] trav_q  [JOINTS];
  logic [PW-1:0]      phase_q [JOINTS];
  logic [PW-1:0]      pstep_q [JOINTS];
  logic [JOINTS-1:0]  fin_q;
  logic [7:0]         period_q;

  mjtg_pkg::state_e   state_q, state_d;
  mjtg_pkg::in_item_t item_q;
  mjtg_pkg::out_item_t res_q, res_d;
  logic               ovalid_q, ovalid_d;
  logic [2:0]         pcnt_q, pcnt_d;
  logic [PW-1:0]      upow_q, upow_d;
  logic signed [F+5:0] acc_q, acc_d;
  logic [PW-1:0]      blend_q, blend_d;

  logic               in_acc;
  logic               jok;
  logic [JW-1:0]      jx;
  logic [23:0]        rate;
  logic signed [32:0] span;
  logic [32:0]        mag;
  logic [32:0]        tmag;
  logic               div_start, div_done;
  logic [NW-1:0]      quot;

  logic [32:0]        mul_a;
  logic [PW-1:0]      mul_b;
  logic [32+PW:0]     mul_p;
  logic [PW-1:0]      mul_t;
  logic [32:0]        delta;

  logic               wr_start, wr_short, wr_abort, wr_tstart, wr_tstep, wr_tend;
  logic [PW-1:0]      new_step;

  always_comb begin
    jok  = (JOINTS >= 2) ? (32'(item_q.joint) < JOINTS) : (item_q.joint == 1'b0);
    jx   = JW'(item_q.joint) & {JW{jok}};
  end

  assign rate = 24'(item_q.speed[14:0]) * 24'((period_q == 8'd0) ? 8'd1 : period_q);
  assign span = 33'(item_q.target_position) - 33'(item_q.current_position);
  assign mag  = span[32] ? 33'(-span) : span;
  assign tmag = trav_q[jx][32] ? 33'(-trav_q[jx]) : trav_q[jx];

  mjtg_divider #(.NW(NW), .DW(33)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (NW'(rate) << F),
    .den_i   (mag),
    .done_o  (div_done),
    .quot_o  (quot)
  );

  // shared multiplier: phase powers, then travel times blend
  assign mul_a = (state_q == mjtg_pkg::S_TRAV) ? tmag : 33'(upow_q);
  assign mul_b = (state_q == mjtg_pkg::S_TRAV) ? blend_q : phase_q[jx];
  assign mul_p = mul_a * mul_b;
  assign mul_t = PW'(mul_p >> F);
  assign delta = 33'(mul_p >> F);
  assign new_step = (quot == '0) ? PW'(1) : PW'(quot);

  always_comb begin
    state_d   = state_q;
    res_d     = res_q;
    ovalid_d  = ovalid_q;
    pcnt_d    = pcnt_q;
    upow_d    = upow_q;
    acc_d     = acc_q;
    blend_d   = blend_q;
    div_start = 1'b0;
    wr_start  = 1'b0;
    wr_short  = 1'b0;
    wr_abort  = 1'b0;
    wr_tstart = 1'b0;
    wr_tstep  = 1'b0;
    wr_tend   = 1'b0;
    if (ovalid_q && !out_stall_i) ovalid_d = 1'b0;
    unique case (state_q)
      mjtg_pkg::S_IDLE: ;
      mjtg_pkg::S_DIV: begin
        res_d.position = item_q.current_position;
        res_d.status   = mjtg_pkg::ST_REJ;
        res_d.moving   = 1'b0;
        if (!jok) begin
          state_d = mjtg_pkg::S_OUT;
        end else begin
          res_d.moving = !fin_q[jx];
          unique case (mjtg_pkg::cmd_e'(item_q.command))
            mjtg_pkg::CMD_START: begin
              if (fin_q[jx] && !item_q.speed[15] && item_q.speed != 16'sd0) begin
                if (mag < 33'(rate)) begin
                  wr_short     = 1'b1;
                  res_d.status = mjtg_pkg::ST_SHORT;
                  state_d      = mjtg_pkg::S_OUT;
                end else begin
                  div_start = 1'b1;
                  state_d   = mjtg_pkg::S_MUL;
                end
              end else begin
                state_d = mjtg_pkg::S_OUT;
              end
            end
            mjtg_pkg::CMD_ABORT: begin
              wr_abort     = 1'b1;
              res_d.status = mjtg_pkg::ST_OK;
              res_d.moving = 1'b0;
              state_d      = mjtg_pkg::S_OUT;
            end
            mjtg_pkg::CMD_TICK: begin
              res_d.status = mjtg_pkg::ST_OK;
              if (fin_q[jx]) begin
                res_d.position = final_q[jx];
                state_d = mjtg_pkg::S_OUT;
              end else if (phase_q[jx] == '0) begin
                res_d.position = start_q[jx];
                wr_tstart = 1'b1;
                state_d = mjtg_pkg::S_OUT;
              end else if ((PW+1)'(phase_q[jx]) + (PW+1)'(pstep_q[jx]) < (PW+1)'(ONE)) begin
                upow_d  = phase_q[jx];
                pcnt_d  = 3'd2;
                acc_d   = '0;
                state_d = mjtg_pkg::S_POLY;
              end else begin
                res_d.position = final_q[jx];
                res_d.moving   = 1'b0;
                wr_tend = 1'b1;
                state_d = mjtg_pkg::S_OUT;
              end
            end
            default: state_d = mjtg_pkg::S_OUT;
          endcase
        end
      end
      mjtg_pkg::S_MUL: begin
        if (div_done) begin
          wr_start     = 1'b1;
          res_d.status = mjtg_pkg::ST_OK;
          res_d.moving = 1'b1;
          state_d      = mjtg_pkg::S_OUT;
        end
      end
      mjtg_pkg::S_POLY: begin
        upow_d = mul_t;
        unique case (pcnt_q)
          3'd3:    acc_d = acc_q + (F+6)'(mul_t) * (F+6)'(10);
          3'd4:    acc_d = acc_q - (F+6)'(mul_t) * (F+6)'(15);
          3'd5:    acc_d = acc_q + (F+6)'(mul_t) * (F+6)'(6);
          default: acc_d = acc_q;
        endcase
        pcnt_d = pcnt_q + 3'd1;
        if (pcnt_q == 3'd5) begin
          pcnt_d  = 3'd0;
          state_d = mjtg_pkg::S_TRAV;
        end
      end
      mjtg_pkg::S_TRAV: begin
        if (acc_q < 0) blend_d = '0;
        else if (acc_q > (F+6)'(ONE)) blend_d = ONE;
        else blend_d = PW'(acc_q);
        pcnt_d  = 3'd0;
        state_d = mjtg_pkg::S_OUT;
        if (pcnt_q == 3'd6) begin
          res_d.position = 32'(33'(start_q[jx]) + (trav_q[jx][32] ? -delta : delta));
          wr_tstep = 1'b1;
        end else begin
          pcnt_d  = 3'd6;
          state_d = mjtg_pkg::S_TRAV;
        end
      end
      mjtg_pkg::S_OUT: begin
        if (!ovalid_q || !out_stall_i) begin
          ovalid_d = 1'b1;
          state_d  = mjtg_pkg::S_IDLE;
        end
      end
      default: state_d = mjtg_pkg::S_IDLE;
    endcase
    if (in_acc) state_d = mjtg_pkg::S_DIV;
  end

  assign in_stall_o = (state_q != mjtg_pkg::S_IDLE) || ovalid_q;
  assign in_acc     = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= mjtg_pkg::S_IDLE;
      ovalid_q <= 1'b0;
      period_q <= 8'd1;
      fin_q    <= '1;
      pcnt_q   <= '0;
      for (int i = 0; i < JOINTS; i++) begin
        start_q[i] <= '0;
        final_q[i] <= '0;
        trav_q[i]  <= '0;
        phase_q[i] <= '0;
        pstep_q[i] <= '0;
      end
    end else begin
      state_q  <= state_d;
      ovalid_q <= ovalid_d;
      pcnt_q   <= pcnt_d;
      if (cfg_we_i) period_q <= cfg_wdata_i;
      if (wr_short || wr_start) begin
        start_q[jx] <= item_q.current_position;
        final_q[jx] <= item_q.target_position;
        trav_q[jx]  <= span;
        phase_q[jx] <= '0;
      end
      if (wr_start) begin
        pstep_q[jx] <= new_step;
        fin_q[jx]   <= 1'b0;
      end
      if (wr_abort) begin
        final_q[jx] <= item_q.target_position;
        phase_q[jx] <= '0;
        fin_q[jx]   <= 1'b1;
      end
      if (wr_tstart || wr_tstep) phase_q[jx] <= phase_q[jx] + pstep_q[jx];
      if (wr_tend) fin_q[jx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) item_q <= in_item_i;
    res_q   <= res_d;
    upow_q  <= upow_d;
    acc_q   <= acc_d;
    blend_q <= blend_d;
  end

  assign out_valid_o = ovalid_q;
  assign out_item_o  = res_q;

  `MJ_ASSERT(a_busy_no_accept, clk_i, rst_ni, !(in_acc && ovalid_q))
  `MJ_ASSERT_NEXT(a_out_from_seq, clk_i, rst_ni, !ovalid_q && state_q != mjtg_pkg::S_OUT, !ovalid_q)
  `MJ_ASSERT(a_status_code, clk_i, rst_ni, !out_valid_o || out_item_o.status != 2'd3)
endmodule
